@@ rtl/qdc_pkg.sv @@
// qdc_pkg: shared types, widths and the phase transition table for the
// quadrature detent counter. No dependencies.
package qdc_pkg;

  localparam int ACCUM_WIDTH = 16;
  localparam int CLICK_WIDTH = 16;
  localparam int PPC_WIDTH   = 8;
  localparam int CNT_W       = $clog2(ACCUM_WIDTH + 1);
  // signed quotient before the clamp to the clicks range
  localparam int QW          = (ACCUM_WIDTH + 1 > CLICK_WIDTH + 1) ?
                               ACCUM_WIDTH + 1 : CLICK_WIDTH + 1;
  // clamped quotient times the divisor with its sign bit
  localparam int PW          = CLICK_WIDTH + PPC_WIDTH + 1;
  localparam int SW          = ((ACCUM_WIDTH > PW) ? ACCUM_WIDTH : PW) + 1;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_RESYNC = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUB
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // step for old phase (upper two bits) and new phase (lower two bits)
  function automatic logic signed [2:0] move_lut(input logic [3:0] idx);
    logic signed [2:0] m;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: m = 3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: m = -3'sd1;
      4'd6:                     m = -3'sd2;
      4'd9:                     m = 3'sd2;
      default:                  m = 3'sd0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/quadrature_detent_counter.sv @@
// quadrature_detent_counter: top level, sequencer, accumulator and output word.
// Depends on qdc_pkg and qdc_div.
//
//   channel | ports                                  | direction
//   in      | in_valid in_stall in_cmd in_phase_a/b  | word in
//   out     | out_valid out_stall out_clicks         | word out, reads only
//   cfg     | cfg_wr_en cfg_wr_data                  | pulses per click
//
// samples, resyncs and unused commands finish in the idle state, back to back.
// a read steps through accept, one divider step per quotient bit, quotient
// pickup, multiply and subtract; its word is registered as the subtract
// step finishes.
// a finished read waits in its last step while an earlier word is stalled.
// synchronous reset clears phase, accumulator and output valid; ppc goes to 4.
module quadrature_detent_counter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_cmd,
  input  logic                                   in_phase_a,
  input  logic                                   in_phase_b,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [qdc_pkg::CLICK_WIDTH-1:0] out_clicks,
  input  logic                                   cfg_wr_en,
  input  logic [qdc_pkg::PPC_WIDTH-1:0]          cfg_wr_data
);
  import qdc_pkg::*;

  localparam logic signed [QW-1:0] Q_MAX = QW'((2 ** (CLICK_WIDTH - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(2 ** (CLICK_WIDTH - 1));
  localparam logic signed [ACCUM_WIDTH:0] A_MAX =
    (ACCUM_WIDTH + 1)'((2 ** (ACCUM_WIDTH - 1)) - 1);
  localparam logic signed [ACCUM_WIDTH:0] A_MIN =
    -(ACCUM_WIDTH + 1)'(2 ** (ACCUM_WIDTH - 1));

  state_t                         state_r, state_nxt;
  logic [PPC_WIDTH-1:0]           ppc_r;
  logic [1:0]                     last_phase_r, last_phase_nxt;
  logic signed [ACCUM_WIDTH-1:0]  accum_r, accum_nxt;
  logic                           neg_r, neg_nxt;
  logic signed [CLICK_WIDTH-1:0]  qsat_r, qsat_nxt;
  logic signed [PW-1:0]           prod_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [CLICK_WIDTH-1:0]  out_clicks_r, out_clicks_nxt;

  logic [PPC_WIDTH-1:0]           divisor;
  logic                           div_start;
  logic [ACCUM_WIDTH-1:0]         div_mag;
  logic [ACCUM_WIDTH-1:0]         quo_mag;
  div_status_t                    div_st;

  logic                           in_acc;
  logic [1:0]                     phase;
  logic signed [ACCUM_WIDTH:0]    sum;
  logic signed [QW-1:0]           q_full;
  logic signed [SW-1:0]           diff;
  logic                           out_free;

  assign divisor  = (ppc_r == '0) ? PPC_WIDTH'(1) : ppc_r;
  assign in_acc   = in_valid && !in_stall;
  assign phase    = {in_phase_b, in_phase_a};
  assign out_free = !out_valid_r || !out_stall;
  assign div_mag  = accum_r[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(-accum_r) : accum_r;

  assign sum = {accum_r[ACCUM_WIDTH-1], accum_r} +
               (ACCUM_WIDTH + 1)'(move_lut({last_phase_r, phase}));

  assign q_full = neg_r ? -QW'({1'b0, quo_mag}) : QW'({1'b0, quo_mag});
  assign diff   = SW'(accum_r) - SW'(prod_r);

  qdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (divisor),
    .quotient (quo_mag),
    .status   (div_st)
  );

  always_comb begin
    state_nxt      = state_r;
    last_phase_nxt = last_phase_r;
    accum_nxt      = accum_r;
    neg_nxt        = neg_r;
    qsat_nxt       = qsat_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_clicks_nxt = out_clicks_r;
    div_start      = 1'b0;
    in_stall       = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_cmd))
            CMD_SAMPLE: begin
              if (sum > A_MAX) begin
                accum_nxt = A_MAX[ACCUM_WIDTH-1:0];
              end else if (sum < A_MIN) begin
                accum_nxt = A_MIN[ACCUM_WIDTH-1:0];
              end else begin
                accum_nxt = sum[ACCUM_WIDTH-1:0];
              end
              last_phase_nxt = phase;
            end
            CMD_READ: begin
              neg_nxt   = accum_r[ACCUM_WIDTH-1];
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
            CMD_RESYNC: begin
              last_phase_nxt = phase;
              accum_nxt      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          if (q_full > Q_MAX) begin
            qsat_nxt = Q_MAX[CLICK_WIDTH-1:0];
          end else if (q_full < Q_MIN) begin
            qsat_nxt = Q_MIN[CLICK_WIDTH-1:0];
          end else begin
            qsat_nxt = q_full[CLICK_WIDTH-1:0];
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        // keep only the remainder of what was reported
        if (out_free) begin
          accum_nxt      = diff[ACCUM_WIDTH-1:0];
          out_valid_nxt  = 1'b1;
          out_clicks_nxt = qsat_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ppc_r        <= PPC_WIDTH'(4);
      last_phase_r <= '0;
      accum_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_phase_r <= last_phase_nxt;
      accum_r      <= accum_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        ppc_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    qsat_r       <= qsat_nxt;
    prod_r       <= qsat_r * $signed({1'b0, divisor});
    out_clicks_r <= out_clicks_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_clicks = out_clicks_r;

endmodule

@@ rtl/qdc_div.sv @@
// qdc_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on qdc_pkg.
module qdc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [qdc_pkg::ACCUM_WIDTH-1:0]  dividend,
  input  logic [qdc_pkg::PPC_WIDTH-1:0]    divisor,
  output logic [qdc_pkg::ACCUM_WIDTH-1:0]  quotient,
  output qdc_pkg::div_status_t             status
);
  import qdc_pkg::*;

  logic [ACCUM_WIDTH-1:0] quo_r, quo_nxt;
  logic [PPC_WIDTH-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [PPC_WIDTH:0]     rem_sh;
  logic [PPC_WIDTH:0]     rem_sub;
  logic                   fits;

  // shared subtract and compare
  assign rem_sh  = {rem_r, quo_r[ACCUM_WIDTH-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(ACCUM_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ACCUM_WIDTH-2:0], fits};
      rem_nxt = fits ? rem_sub[PPC_WIDTH-1:0] : rem_sh[PPC_WIDTH-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

@@ rtl/qdc_checker.sv @@
// qdc_checker: port-level assertions for the quadrature detent counter,
// bound to the top level. Depends on qdc_pkg.
module qdc_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic [1:0]                             in_cmd,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [qdc_pkg::CLICK_WIDTH-1:0] out_clicks
);
  import qdc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_clicks))
    else $error("stalled output word changed");

  // a read keeps the input side busy while it divides
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_READ |=> in_stall)
    else $error("input taken during a read");

  // samples, resyncs and unused commands leave the block ready
  a_fast_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd != CMD_READ |=> !in_stall)
    else $error("block busy after a one-cycle command");

  // a new result only appears at the end of a read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a read");

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_cmd     (in_cmd),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_clicks (out_clicks)
);
